// File: src/malc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malc_pkg
// shared widths, codes and controller/datapath interface types for the
// moisture average level classifier
// ----------------------------------------------------------------------------
package malc_pkg;

    // window of recent samples
    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 12;
    localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);

    // result field widths
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 3;
    localparam int HYST_W  = 6;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // serial divider: wide enough for 2*sum+count and for diff*100
    localparam int PCT_PROD_W = SAMPLE_W + PCT_W;
    localparam int MEAN_NUM_W = SUM_W + 1;
    localparam int DIV_NUM_W  = (MEAN_NUM_W > PCT_PROD_W) ? MEAN_NUM_W : PCT_PROD_W;
    localparam int DIV_DEN_W  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // moisture level codes
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_WATER_NOW = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_SOON      = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_OK        = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_OVER      = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_UNKNOWN   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_FLOOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_FULL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_BELOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOON_BELOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_BELOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_BELOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch sample, read oldest ring entry
        logic update;      // ring write, sum and fill update
        logic div_mean;    // start divider on the mean
        logic mean_load;   // take mean from divider
        logic pct_eval;    // clamp percent when mean is outside the span
        logic div_pct;     // start divider on the percent
        logic pct_load;    // take percent from divider
        logic class_load;  // classify and load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic pct_direct;
        logic out_free;
    } t_sts;

endpackage

// File: src/malc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module malc_div
    import malc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_q[DIV_NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/malc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malc_dp
// datapath: sample ring, running sum, config registers, divider,
// level classification and output register
// ----------------------------------------------------------------------------
module malc_dp
    import malc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [SAMPLE_W-1:0]   o_mean_raw,
    output logic [PCT_W-1:0]      o_percent,
    output logic [LEVEL_W-1:0]    o_level
);

    // config registers
    logic [SAMPLE_W-1:0] r_dry_floor;
    logic [SAMPLE_W-1:0] r_wet_full;
    logic [PCT_W-1:0]    r_ok_below;
    logic [PCT_W-1:0]    r_soon_below;
    logic [PCT_W-1:0]    r_now_below;
    logic [PCT_W-1:0]    r_crit_below;
    logic [HYST_W-1:0]   r_hyst;

    // window state
    logic [SAMPLE_W-1:0] r_ring [WINDOW_DEPTH];
    logic [POS_W-1:0]    r_pos;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [LEVEL_W-1:0]  r_prev_level;
    logic                r_out_valid;

    // per-item payload
    logic [SAMPLE_W-1:0] r_raw;
    logic [SAMPLE_W-1:0] r_old;
    logic [SAMPLE_W-1:0] r_mean;
    logic [PCT_W-1:0]    r_pct;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [PCT_W-1:0]    r_out_pct;
    logic [LEVEL_W-1:0]  r_out_level;

    logic                  full;
    logic [SUM_W-1:0]      n_sum;
    logic [POS_W-1:0]      n_pos;
    logic [MEAN_NUM_W-1:0] mean_num;
    logic [PCT_PROD_W-1:0] pct_prod;
    logic [SAMPLE_W-1:0]   span;
    logic                  mean_dry;
    logic                  mean_wet;
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_quot;
    logic [LEVEL_W-1:0]    level;

    function automatic logic below_band(input logic [PCT_W-1:0] pct,
                                        input logic [PCT_W-1:0] bound,
                                        input logic [HYST_W-1:0] hy);
        logic [PCT_W-1:0] lo;
        lo = ({1'b0, bound} > {2'b0, hy}) ? bound - PCT_W'(hy) : '0;
        return (pct >= lo) && (pct < bound);
    endfunction

    function automatic logic above_band(input logic [PCT_W-1:0] pct,
                                        input logic [PCT_W-1:0] bound,
                                        input logic [HYST_W-1:0] hy);
        logic [PCT_W:0] hi;
        hi = {1'b0, bound} + {2'b0, hy};
        return (pct >= bound) && ({1'b0, pct} < hi);
    endfunction

    // raw level, then hold the previous level inside its hysteresis bands
    always_comb begin
        logic [LEVEL_W-1:0] raw_lvl;
        logic               hold;
        if (r_pct >= r_ok_below) begin
            raw_lvl = LVL_OVER;
        end else if (r_pct >= r_soon_below) begin
            raw_lvl = LVL_OK;
        end else if (r_pct >= r_now_below) begin
            raw_lvl = LVL_SOON;
        end else if (r_pct >= r_crit_below) begin
            raw_lvl = LVL_WATER_NOW;
        end else begin
            raw_lvl = LVL_CRITICAL;
        end
        case (r_prev_level)
            LVL_OVER: begin
                hold = below_band(r_pct, r_ok_below, r_hyst);
            end
            LVL_OK: begin
                hold = below_band(r_pct, r_soon_below, r_hyst)
                    || above_band(r_pct, r_ok_below, r_hyst);
            end
            LVL_SOON: begin
                hold = below_band(r_pct, r_now_below, r_hyst)
                    || above_band(r_pct, r_soon_below, r_hyst);
            end
            LVL_WATER_NOW: begin
                hold = below_band(r_pct, r_crit_below, r_hyst)
                    || above_band(r_pct, r_now_below, r_hyst);
            end
            LVL_CRITICAL: begin
                hold = above_band(r_pct, r_crit_below, r_hyst);
            end
            default: begin
                hold = 1'b0;
            end
        endcase
        level = (hold && (raw_lvl != r_prev_level)) ? r_prev_level : raw_lvl;
    end

    assign full  = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign n_sum = r_sum - (full ? SUM_W'(r_old) : '0) + SUM_W'(r_raw);
    assign n_pos = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + POS_W'(1);

    assign mean_num = {r_sum, 1'b0} + MEAN_NUM_W'(r_fill);
    assign pct_prod = PCT_PROD_W'(r_dry_floor - r_mean) * PCT_PROD_W'(PCT_FULL);
    assign span     = r_dry_floor - r_wet_full;
    assign mean_dry = (r_mean >= r_dry_floor);
    assign mean_wet = (r_mean <= r_wet_full);

    assign div_start = i_cmd.div_mean | i_cmd.div_pct;
    assign div_num   = i_cmd.div_mean ? DIV_NUM_W'(mean_num) : DIV_NUM_W'(pct_prod);
    assign div_den   = i_cmd.div_mean ? DIV_DEN_W'({r_fill, 1'b0}) : span;

    malc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // config and window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_floor  <= SAMPLE_W'(3000);
            r_wet_full   <= SAMPLE_W'(1300);
            r_ok_below   <= PCT_W'(80);
            r_soon_below <= PCT_W'(40);
            r_now_below  <= PCT_W'(25);
            r_crit_below <= PCT_W'(10);
            r_hyst       <= HYST_W'(3);
            r_pos        <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_prev_level <= LVL_UNKNOWN;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRY_FLOOR:  r_dry_floor  <= i_cfg_data;
                    CFG_WET_FULL:   r_wet_full   <= i_cfg_data;
                    CFG_OK_BELOW:   r_ok_below   <= i_cfg_data[PCT_W-1:0];
                    CFG_SOON_BELOW: r_soon_below <= i_cfg_data[PCT_W-1:0];
                    CFG_NOW_BELOW:  r_now_below  <= i_cfg_data[PCT_W-1:0];
                    CFG_CRIT_BELOW: r_crit_below <= i_cfg_data[PCT_W-1:0];
                    CFG_HYSTERESIS: r_hyst       <= i_cfg_data[HYST_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_sum <= n_sum;
                r_pos <= n_pos;
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.class_load) begin
                r_prev_level <= level;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_pos] <= r_raw;
        end
        if (i_cmd.capture) begin
            r_old <= r_ring[r_pos];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= i_raw_sample;
        end
        if (i_cmd.mean_load) begin
            r_mean <= div_quot[SAMPLE_W-1:0];
        end
        if (i_cmd.pct_eval && mean_dry) begin
            r_pct <= '0;
        end else if (i_cmd.pct_eval && mean_wet) begin
            r_pct <= PCT_FULL;
        end else if (i_cmd.pct_load) begin
            r_pct <= div_quot[PCT_W-1:0];
        end
        if (i_cmd.class_load) begin
            r_out_mean  <= r_mean;
            r_out_pct   <= r_pct;
            r_out_level <= level;
        end
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.pct_direct = mean_dry | mean_wet;
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid    = r_out_valid;
    assign o_mean_raw = r_out_mean;
    assign o_percent  = r_out_pct;
    assign o_level    = r_out_level;

endmodule

// File: src/malc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malc_ctrl
// sequencer: one item at a time through window update, one or two divisions
// and classification
// ----------------------------------------------------------------------------
module malc_ctrl
    import malc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_UPD       = 7'b0000010,
        S_MEAN_GO   = 7'b0000100,
        S_MEAN_WAIT = 7'b0001000,
        S_PCT       = 7'b0010000,
        S_PCT_WAIT  = 7'b0100000,
        S_CLASS     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_MEAN_GO;
            end
            S_MEAN_GO: begin
                o_cmd.div_mean = 1'b1;
                n_state        = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_load = 1'b1;
                    n_state         = S_PCT;
                end
            end
            S_PCT: begin
                o_cmd.pct_eval = 1'b1;
                if (i_sts.pct_direct) begin
                    n_state = S_CLASS;
                end else begin
                    o_cmd.div_pct = 1'b1;
                    n_state       = S_PCT_WAIT;
                end
            end
            S_PCT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.pct_load = 1'b1;
                    n_state        = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.out_free) begin
                    o_cmd.class_load = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: src/moisture_average_level_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moisture_average_level_classifier_unit
// moving-average moisture classifier with hysteresis
// ----------------------------------------------------------------------------
// Each transfer on the input channel brings one 12-bit converter sample; each
// produces exactly one result transfer carrying the rounded window mean, the
// moisture percentage and the moisture level (0 critical .. 4 overwatered).
// Items are worked one at a time. The one shared serial divider is used once
// for the mean and, when the mean lies inside the calibration span, once
// more for the percentage; outside the span the percentage is clamped.
// The result sits in an output register, so the next sample is taken while
// an earlier result still waits on a stalled output. Configuration writes
// (index 0 dry floor .. 6 hysteresis, index 7 ignored) take effect at once
// and are meant for idle periods only. The sample window needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module moisture_average_level_classifier_unit
    import malc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    // result output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_mean_raw,
    output logic [PCT_W-1:0]      o_percent,
    output logic [LEVEL_W-1:0]    o_level,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: accepts a sample only when idle
    malc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: window, divider, classification, output register
    malc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_raw_sample (i_raw_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_mean_raw   (o_mean_raw),
        .o_percent    (o_percent),
        .o_level      (o_level)
    );

endmodule

// File: src/malc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malc_chk
// port-level checks on the classifier, bound to the top level
// ----------------------------------------------------------------------------
module malc_chk
    import malc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [SAMPLE_W-1:0]   o_mean_raw,
    input logic [PCT_W-1:0]      o_percent,
    input logic [LEVEL_W-1:0]    o_level
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mean_raw)
            && $stable(o_percent) && $stable(o_level)))
        else $error("stalled result changed");

    // one item in flight: busy right after an input transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transfer");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_percent <= PCT_FULL))
        else $error("percent above full scale");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= LVL_OVER))
        else $error("level code out of range");

endmodule

bind moisture_average_level_classifier_unit malc_chk u_malc_chk (.*);
